FILE: design/radius_match_hit_filter_defines.svh
// Assertion macros shared by the radius match hit filter RTL.
`ifndef RADIUS_MATCH_HIT_FILTER_DEFINES_SVH
`define RADIUS_MATCH_HIT_FILTER_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low
`define RMHF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low
`define RMHF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rmhf_pkg.sv
// Types and constants of the radius match hit filter.
`default_nettype none

package rmhf_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned SQ_W   = 32;          // one squared difference of two 16-bit positions
  localparam int unsigned DIST_W = SQ_W + 2;    // sum of three squares
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_AW = 2;

  // Request kind carried in tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TEST  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_BEAM_LOW  = 2'd0,
    CFG_BEAM_HIGH = 2'd1,
    CFG_RADIUS    = 2'd2
  } cfg_e;

  // One item traveling down the cell chain
  typedef struct packed {
    logic                    vld;
    req_e                    kind;
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    band;  // test hit inside beam band, never kept
    logic                    flag;  // load: stored; test: matched
  } item_t;

endpackage

`default_nettype wire

FILE: design/rmhf_cell.sv
// One candidate cell: holds a candidate and checks passing test hits against it.
`default_nettype none

`include "radius_match_hit_filter_defines.svh"

module rmhf_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [rmhf_pkg::SQ_W-1:0]   r2_i,
  input  rmhf_pkg::item_t             item_i,
  output rmhf_pkg::item_t             item_o
);

  // Stored candidate
  logic signed [rmhf_pkg::POS_W-1:0] cx_q, cy_q, cz_q;
  logic                              cvld_q, cvld_d;

  // Stage A: squared differences
  rmhf_pkg::item_t            a_q, a_d;
  logic [rmhf_pkg::SQ_W-1:0]  sqx_q, sqy_q, sqz_q;
  logic                       a_hit_q;

  // Stage B: distance compare
  rmhf_pkg::item_t            b_q, b_d;

  logic signed [rmhf_pkg::POS_W:0]       dx, dy, dz;
  logic signed [2*rmhf_pkg::POS_W+1:0]   px, py, pz;
  logic [rmhf_pkg::DIST_W-1:0]           dist2;
  logic                                  capture;

  // Differences and squares against the held candidate
  assign dx = {item_i.x[rmhf_pkg::POS_W-1], item_i.x} - {cx_q[rmhf_pkg::POS_W-1], cx_q};
  assign dy = {item_i.y[rmhf_pkg::POS_W-1], item_i.y} - {cy_q[rmhf_pkg::POS_W-1], cy_q};
  assign dz = {item_i.z[rmhf_pkg::POS_W-1], item_i.z} - {cz_q[rmhf_pkg::POS_W-1], cz_q};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // First empty cell takes a load that nobody stored yet
  assign capture = item_i.vld && (item_i.kind == rmhf_pkg::REQ_LOAD) &&
                   !item_i.flag && !cvld_q;

  always_comb begin
    a_d    = item_i;
    cvld_d = cvld_q;
    if (item_i.vld && (item_i.kind == rmhf_pkg::REQ_CLEAR)) begin
      cvld_d = 1'b0;
    end else if (capture) begin
      cvld_d   = 1'b1;
      a_d.flag = 1'b1;
    end
  end

  // Sum of squares against squared radius
  assign dist2 = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};

  always_comb begin
    b_d = a_q;
    if (a_q.vld && (a_q.kind == rmhf_pkg::REQ_TEST) && a_hit_q && !a_q.band &&
        (dist2 < {2'b00, r2_i})) begin
      b_d.flag = 1'b1;
    end
  end

  // Control and stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q  <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      a_hit_q <= 1'b0;
    end else if (adv_i) begin
      cvld_q  <= cvld_d;
      a_q     <= a_d;
      b_q     <= b_d;
      a_hit_q <= cvld_q;
    end
  end

  // Payload: candidate position and squares
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sqx_q <= px[rmhf_pkg::SQ_W-1:0];
      sqy_q <= py[rmhf_pkg::SQ_W-1:0];
      sqz_q <= pz[rmhf_pkg::SQ_W-1:0];
      if (capture) begin
        cx_q <= item_i.x;
        cy_q <= item_i.y;
        cz_q <= item_i.z;
      end
    end
  end

  assign item_o = b_q;

  `RMHF_ASSERT_NXT(a_clear_empties, adv_i && item_i.vld && (item_i.kind == rmhf_pkg::REQ_CLEAR), !cvld_q, "clear transfer left cell occupied")
  `RMHF_ASSERT_IMP(a_fill_by_load, $rose(cvld_q), $past(adv_i && capture), "cell filled without a load")
  `RMHF_ASSERT_IMP(a_one_capture, capture, !item_i.flag, "load stored twice")

endmodule

`default_nettype wire

FILE: design/radius_match_hit_filter.sv
// Top level of the radius match hit filter: stream ports, config and cell chain.
// The block keeps up to CANDIDATE_DEPTH candidates, one per cell of a chain.
// Every request (load, test, clear) walks down the chain in arrival order;
// each cell spends two register stages on it (squared differences, then the
// sum and radius compare), and a result register follows the last cell; one
// request is taken every cycle while the result side keeps up. Loads whose x
// is inside the beam band and unused request codes are dropped at the input.
// A load that finds every cell full sets the overflow flag when it leaves
// the chain; results report the flag as it stands after all earlier requests.
// Only a clear empties the store. Registers must be written only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

`include "radius_match_hit_filter_defines.svh"

module radius_match_hit_filter #(
  parameter int unsigned CANDIDATE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [63:0]                   s_axis_tdata_i,  // hit_id, pos_x, pos_y, pos_z
  input  logic [1:0]                    s_axis_tuser_i,  // req_type
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,  // result_id
  output logic [1:0]                    m_axis_tuser_o,  // keep, store_overflowed
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [rmhf_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [rmhf_pkg::CFG_W-1:0]    cfg_wdata_i
);

  logic signed [rmhf_pkg::POS_W-1:0] beam_lo_q, beam_hi_q;
  logic [rmhf_pkg::CFG_W-1:0]        radius_q;
  logic [rmhf_pkg::SQ_W-1:0]         r2_q;

  rmhf_pkg::item_t chain [CANDIDATE_DEPTH+1];
  rmhf_pkg::item_t entry, tail;

  logic                              adv;
  logic                              in_band;
  logic signed [rmhf_pkg::POS_W-1:0] in_x;
  logic                              ovf_q;
  logic                              out_vld_q, out_keep_q, out_ovf_q;
  logic [rmhf_pkg::ID_W-1:0]         out_id_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_lo_q <= 16'sh8000;
      beam_hi_q <= 16'sh8000;
      radius_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (rmhf_pkg::cfg_e'(cfg_addr_i))
        rmhf_pkg::CFG_BEAM_LOW:  beam_lo_q <= cfg_wdata_i;
        rmhf_pkg::CFG_BEAM_HIGH: beam_hi_q <= cfg_wdata_i;
        rmhf_pkg::CFG_RADIUS:    radius_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Squared radius, registered from the radius register
  always_ff @(posedge clk_i) begin
    r2_q <= {16'b0, radius_q} * {16'b0, radius_q};
  end

  // Whole chain moves when the result register can take a transfer
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Input decode and beam band test
  assign in_x    = s_axis_tdata_i[31:16];
  assign in_band = !((in_x < beam_lo_q) || (beam_hi_q < in_x));

  always_comb begin
    entry      = '0;
    entry.kind = rmhf_pkg::req_e'(s_axis_tuser_i);
    entry.id   = s_axis_tdata_i[15:0];
    entry.x    = s_axis_tdata_i[31:16];
    entry.y    = s_axis_tdata_i[47:32];
    entry.z    = s_axis_tdata_i[63:48];
    entry.band = in_band;
    case (rmhf_pkg::req_e'(s_axis_tuser_i))
      rmhf_pkg::REQ_LOAD:  entry.vld = s_axis_tvalid_i && !in_band;
      rmhf_pkg::REQ_TEST:  entry.vld = s_axis_tvalid_i;
      rmhf_pkg::REQ_CLEAR: entry.vld = s_axis_tvalid_i;
      default:             entry.vld = 1'b0;
    endcase
  end

  assign chain[0] = entry;

  // Candidate cells
  for (genvar g = 0; g < CANDIDATE_DEPTH; g++) begin : g_cell
    rmhf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .r2_i   (r2_q),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  assign tail = chain[CANDIDATE_DEPTH];

  // Overflow flag and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= tail.vld && (tail.kind == rmhf_pkg::REQ_TEST);
      if (tail.vld && (tail.kind == rmhf_pkg::REQ_LOAD) && !tail.flag) begin
        ovf_q <= 1'b1;
      end else if (tail.vld && (tail.kind == rmhf_pkg::REQ_CLEAR)) begin
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_id_q   <= tail.id;
      out_keep_q <= tail.flag;
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_id_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_keep_q};

  `RMHF_ASSERT_IMP(a_ovf_clear_only, $fell(ovf_q), $past(adv && tail.vld && (tail.kind == rmhf_pkg::REQ_CLEAR)), "overflow flag dropped without a clear")
  `RMHF_ASSERT_IMP(a_result_from_test, $rose(out_vld_q), $past(tail.vld && (tail.kind == rmhf_pkg::REQ_TEST)), "result without a test hit")
  `RMHF_ASSERT_IMP(a_band_never_kept, adv && tail.vld && (tail.kind == rmhf_pkg::REQ_TEST) && tail.band, !tail.flag, "in-band hit marked as kept")

endmodule

`default_nettype wire
